// File: design/srt_radix16_divider_64by32_assert.svh
// ----------------------------------------------------------------------------
// srt_radix16_divider_64by32 assertion macros
// Shared concurrent assertion forms for the divider modules.
// ----------------------------------------------------------------------------
`ifndef SRT_RADIX16_DIVIDER_64BY32_ASSERT_SVH
`define SRT_RADIX16_DIVIDER_64BY32_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/srtd_pkg.sv
// ----------------------------------------------------------------------------
// srtd_pkg
// Types and constants shared by the radix-16 divider modules.
// ----------------------------------------------------------------------------
package srtd_pkg;

  localparam int unsigned DivndW = 64;
  localparam int unsigned DivsrW = 32;
  localparam int unsigned DigitW = 4;
  localparam int unsigned Radix  = 16;
  localparam int unsigned Digits = DivndW / DigitW;
  localparam int unsigned PartW  = DivsrW + DigitW;

  typedef logic [PartW-1:0] multiple_t;

  // One classified operation, as it travels from front to back.
  typedef struct packed {
    logic [DivndW-1:0]           a_mag;
    multiple_t [Radix-1:0]       mult;
    logic                        neg_a;
    logic                        neg_d;
    logic                        sgn;
    logic                        dz;
  } op_t;

  // One digit-pipeline stage.
  typedef struct packed {
    logic [DivndW-1:0] a_rest;
    logic [DivndW-1:0] q_mag;
    logic [DivsrW-1:0] r_mag;
    op_t               op;
  } stage_t;

endpackage

// File: design/srtd_front.sv
// ----------------------------------------------------------------------------
// srtd_front
// Takes an item, forms operand magnitudes, signs and the divisor multiples.
// ----------------------------------------------------------------------------
module srtd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      signed_mode,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [srtd_pkg::DivndW-1:0] dividend,
  input  logic [srtd_pkg::DivsrW-1:0] divisor,
  output logic                      op_valid,
  input  logic                      op_ready,
  output srtd_pkg::op_t             op
);

  logic          fr_valid;
  srtd_pkg::op_t fr_op;
  srtd_pkg::op_t op_next;
  logic [srtd_pkg::DivsrW-1:0] d_mag;
  logic          load;

  assign in_stall = fr_valid && !op_ready;
  assign load     = in_valid && !in_stall;
  assign op_valid = fr_valid;
  assign op       = fr_op;

  always_comb begin
    op_next.sgn   = signed_mode;
    op_next.neg_a = signed_mode && dividend[srtd_pkg::DivndW-1];
    op_next.neg_d = signed_mode && divisor[srtd_pkg::DivsrW-1];
    // most negative values wrap onto their exact magnitude
    op_next.a_mag = op_next.neg_a ? (~dividend + 1'b1) : dividend;
    d_mag         = op_next.neg_d ? (~divisor + 1'b1) : divisor;
    op_next.dz    = (d_mag == '0);
    for (int k = 0; k < srtd_pkg::Radix; k++) begin
      op_next.mult[k] = srtd_pkg::PartW'(d_mag) * srtd_pkg::PartW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (!in_stall) begin
      fr_valid <= in_valid;
    end
    if (load) begin
      fr_op <= op_next;
    end
  end

endmodule

// File: design/srtd_queue.sv
// ----------------------------------------------------------------------------
// srtd_queue
// Short register queue between the front and the digit pipeline.
// ----------------------------------------------------------------------------
`include "srt_radix16_divider_64by32_assert.svh"

module srtd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  srtd_pkg::op_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output srtd_pkg::op_t pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  srtd_pkg::op_t       slots [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                push;
  logic                pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `SRTD_ASSERT_NOW(a_cnt_bound, 1'b1, count <= CntW'(DEPTH), "queue count past depth")
  `SRTD_ASSERT_NEXT(a_cnt_inc, push && !pop, count == $past(count) + 1'b1, "count not raised")
  `SRTD_ASSERT_NEXT(a_cnt_dec, pop && !push, count == $past(count) - 1'b1, "count not lowered")

endmodule

// File: design/srtd_back.sv
// ----------------------------------------------------------------------------
// srtd_back
// Radix-16 digit pipeline, one quotient digit per stage, and result format.
// ----------------------------------------------------------------------------
`include "srt_radix16_divider_64by32_assert.svh"

module srtd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      op_valid,
  output logic                      op_ready,
  input  srtd_pkg::op_t             op,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [srtd_pkg::DivsrW-1:0] quotient,
  output logic [srtd_pkg::DivsrW-1:0] remainder,
  output logic                      divide_by_zero,
  output logic                      quotient_overflow
);

  localparam int unsigned N  = srtd_pkg::Digits;
  localparam int unsigned DW = srtd_pkg::DivsrW;
  localparam int unsigned AW = srtd_pkg::DivndW;
  localparam int unsigned GW = srtd_pkg::DigitW;

  srtd_pkg::stage_t st   [N+1];
  srtd_pkg::stage_t st_next [N+1];
  logic [N:0]       vld;
  logic             advance;

  assign advance  = !(vld[N] && out_stall);
  assign op_ready = advance;

  always_comb begin
    st_next[0].a_rest = op.a_mag;
    st_next[0].q_mag  = '0;
    st_next[0].r_mag  = '0;
    st_next[0].op     = op;
  end

  for (genvar i = 1; i <= N; i++) begin : g_digit
    logic [srtd_pkg::PartW-1:0] part;
    logic [GW-1:0]              digit;
    logic [srtd_pkg::PartW-1:0] diff;
    always_comb begin
      part  = {st[i-1].r_mag, st[i-1].a_rest[AW-1 -: GW]};
      digit = '0;
      // pick the largest multiple that still fits
      for (int k = 1; k < srtd_pkg::Radix; k++) begin
        if (part >= st[i-1].op.mult[k]) begin
          digit = GW'(k);
        end
      end
      diff             = part - st[i-1].op.mult[digit];
      st_next[i].a_rest = {st[i-1].a_rest[AW-GW-1:0], {GW{1'b0}}};
      st_next[i].q_mag  = {st[i-1].q_mag[AW-GW-1:0], digit};
      st_next[i].r_mag  = diff[DW-1:0];
      st_next[i].op     = st[i-1].op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[N-1:0], op_valid};
    end
    if (advance) begin
      for (int i = 0; i <= N; i++) begin
        st[i] <= st_next[i];
      end
    end
  end

  logic [AW-1:0] qm;
  logic [DW-1:0] r_signed;
  logic          neg_q;
  logic          ovf;

  always_comb begin
    qm       = st[N].q_mag;
    r_signed = st[N].op.neg_a ? (~st[N].r_mag + 1'b1) : st[N].r_mag;
    neg_q    = st[N].op.neg_a != st[N].op.neg_d;
    if (!st[N].op.sgn) begin
      ovf = (qm[AW-1:DW] != '0);
    end else if (neg_q) begin
      ovf = (qm > AW'({1'b1, {(DW-1){1'b0}}}));
    end else begin
      ovf = (qm > AW'({(DW-1){1'b1}}));
    end
    if (st[N].op.dz) begin
      quotient          = '1;
      remainder         = '0;
      divide_by_zero    = 1'b1;
      quotient_overflow = 1'b0;
    end else begin
      quotient          = ovf ? '1
                        : ((st[N].op.sgn && neg_q) ? (~qm[DW-1:0] + 1'b1) : qm[DW-1:0]);
      remainder         = r_signed;
      divide_by_zero    = 1'b0;
      quotient_overflow = ovf;
    end
  end

  assign out_valid = vld[N];

  `SRTD_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid, "stalled result lost")
  `SRTD_ASSERT_NOW(a_dz_form, out_valid && divide_by_zero,
    quotient == '1 && remainder == '0 && !quotient_overflow, "bad divide-by-zero result")
  `SRTD_ASSERT_NOW(a_ovf_ones, out_valid && quotient_overflow, quotient == '1,
    "overflow quotient not all ones")

endmodule

// File: design/srt_radix16_divider_64by32.sv
// ----------------------------------------------------------------------------
// srt_radix16_divider_64by32
// 64-by-32 divider: operand front end, queue, radix-16 digit pipeline.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid / in_stall  | dividend, divisor
// out      | out_valid / out_stall| quotient, remainder, divide_by_zero,
//          |                      | quotient_overflow
// cfg      | cfg_wr_en            | cfg_wr_data (signed_mode)
//
// One item per cycle sustained while no result is held by out_stall. With an empty
// queue an item passes the front register, one queue slot, one pipeline
// input stage, then one stage per radix-16 digit (sixteen).
// rst is synchronous and clears all valid flags and signed_mode.
// out_stall with a result waiting freezes the digit pipeline; the queue then absorbs front items.
// ----------------------------------------------------------------------------
module srt_radix16_divider_64by32 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] quotient,
  output logic [31:0] remainder,
  output logic        divide_by_zero,
  output logic        quotient_overflow
);

  logic          signed_mode;
  logic          f_valid, f_ready, b_valid, b_ready;
  srtd_pkg::op_t f_op, b_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      signed_mode <= cfg_wr_data;
    end
  end

  srtd_front u_front (
    .clk, .rst, .signed_mode, .in_valid, .in_stall, .dividend, .divisor,
    .op_valid (f_valid), .op_ready (f_ready), .op (f_op)
  );

  srtd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .push_valid (f_valid), .push_ready (f_ready), .push_data (f_op),
    .pop_valid (b_valid), .pop_ready (b_ready), .pop_data (b_op)
  );

  srtd_back u_back (
    .clk, .rst, .op_valid (b_valid), .op_ready (b_ready), .op (b_op),
    .out_valid, .out_stall, .quotient, .remainder, .divide_by_zero,
    .quotient_overflow
  );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the 64-by-32 divider against an in-bench division predictor in both
// unsigned and signed mode, with random gaps on input and output and a long
// output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_op_t;

  typedef struct packed {
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic        dz;
    logic        ov;
  } div_res_t;

  localparam int Latency = 18;
  localparam longint CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] dividend = '0;
  logic [31:0] divisor = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] quotient;
  logic [31:0] remainder;
  logic        divide_by_zero;
  logic        quotient_overflow;

  div_op_t  pending_ops[$];
  div_res_t expected_results[$];
  logic     mode_shadow = 1'b0;
  int       error_count = 0;
  int       results_seen = 0;
  int       signed_items = 0;
  int       unsigned_items = 0;
  int       hold_cycles = 0;
  int       in_gap = 0;
  longint   cycle_count = 0;
  bit       stall_enable = 1'b1;

  srt_radix16_divider_64by32 u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .dividend(dividend),
    .divisor(divisor), .out_valid(out_valid), .out_stall(out_stall),
    .quotient(quotient), .remainder(remainder), .divide_by_zero(divide_by_zero),
    .quotient_overflow(quotient_overflow)
  );

  always #5 clk = ~clk;

  function automatic div_res_t divide_predict(div_op_t op, logic sgn);
    div_res_t   res;
    logic       neg_a;
    logic       neg_d;
    logic       neg_q;
    logic [63:0] a_mag;
    logic [63:0] d_mag;
    logic [63:0] q_mag;
    logic [63:0] r_mag;
    neg_a = sgn & op.dividend[63];
    neg_d = sgn & op.divisor[31];
    a_mag = neg_a ? -op.dividend : op.dividend;
    d_mag = {32'b0, neg_d ? -op.divisor : op.divisor};
    if (neg_d && d_mag == 64'd0) d_mag = 64'h8000_0000;
    res = '0;
    if (d_mag == 64'd0) begin
      res.quotient = '1;
      res.dz = 1'b1;
      return res;
    end
    q_mag = a_mag / d_mag;
    r_mag = a_mag % d_mag;
    res.remainder = neg_a ? -r_mag[31:0] : r_mag[31:0];
    neg_q = neg_a ^ neg_d;
    if (!sgn) begin
      res.ov = q_mag > 64'hFFFF_FFFF;
    end else begin
      res.ov = neg_q ? (q_mag > 64'h8000_0000) : (q_mag > 64'h7FFF_FFFF);
    end
    if (res.ov) res.quotient = '1;
    else res.quotient = neg_q ? -q_mag[31:0] : q_mag[31:0];
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got,
             want);
    error_count++;
  endtask

  // Driver: present queued items, hold while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(divide_predict({dividend, divisor}, mode_shadow));
        if (mode_shadow) signed_items++;
        else unsigned_items++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          div_op_t op;
          op = pending_ops.pop_front();
          dividend <= op.dividend;
          divisor <= op.divisor;
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare accepted results with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result quotient", quotient, '0);
      end else begin
        div_res_t want;
        want = expected_results.pop_front();
        if (quotient !== want.quotient) report_mismatch("quotient", quotient, want.quotient);
        if (remainder !== want.remainder)
          report_mismatch("remainder", remainder, want.remainder);
        if (divide_by_zero !== want.dz)
          report_mismatch("divide_by_zero", divide_by_zero, want.dz);
        if (quotient_overflow !== want.ov)
          report_mismatch("quotient_overflow", quotient_overflow, want.ov);
      end
      results_seen++;
    end
  end

  // Receiver stall: long hold-off when requested, else random gaps.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (!stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (pick_gap() > 1);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_op(logic [63:0] a, logic [31:0] d);
    pending_ops.push_back({a, d});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Half the items are well-formed: dividend below divisor << 32 so no unsigned overflow.
  task automatic add_random(int count);
    logic [63:0] a;
    logic [31:0] d;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: d = 32'd0;
        1: d = $urandom_range(0, 15);
        2: d = 32'hFFFF_FFFF - $urandom_range(0, 3);
        3: d = 32'h8000_0000 ^ $urandom_range(0, 1);
        default: d = $urandom() >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 5))
        0: a = rand64();
        1: a = rand64() >> $urandom_range(0, 63);
        2: a = -(rand64() >> $urandom_range(1, 63));
        default: a = {($urandom() % (d == 0 ? 32'd1 : d)) >> $urandom_range(0, 1), $urandom()};
      endcase
      add_op(a, d);
    end
  endtask

  task automatic drain_and_set_mode(logic m);
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_shadow = m;
  endtask

  task automatic add_directed();
    add_op(64'd0, 32'd1);
    add_op(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    add_op(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
    add_op(64'h1234_5678_9ABC_DEF0, 32'd0);
    add_op(64'h0, 32'd0);
    add_op(64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
    add_op(64'h8000_0000_0000_0000, 32'h8000_0000);
    add_op(64'hFFFF_FFFF_8000_0000, 32'hFFFF_FFFF);
    add_op(64'h0000_0000_7FFF_FFFF, 32'd1);
    add_op(64'h0000_0000_8000_0000, 32'd1);
    add_op(64'hFFFF_FFFF_8000_0000, 32'd1);
    add_op(64'hFFFF_FFFE_FFFF_FFFF, 32'hFFFF_FFFF);
    add_op(64'd100, 32'hFFFF_FFF9);
    add_op(-64'd100, 32'd7);
    add_op(-64'd100, 32'hFFFF_FFF9);
    add_op(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    add_op(64'd6, 32'd3);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    add_directed();
    add_random(300);
    // Fill the block: hold the output off while the sender keeps going.
    hold_cycles <= 200;
    add_random(60);
    drain_and_set_mode(1'b1);
    add_directed();
    add_random(400);
    drain_and_set_mode(1'b0);
    add_random(300);
    drain_and_set_mode(1'b1);
    stall_enable = 1'b0;
    add_random(150);
    drain_and_set_mode(1'b1);
    stall_enable = 1'b1;
    add_random(200);
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("Covered %0d unsigned and %0d signed divisions, %0d results checked,",
             unsigned_items, signed_items, results_seen);
    $display("including zero divisors, overflow, extreme operands and output hold-off.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
